FILE: rtl/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

    // Q1.15 unity
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // Hue sector codes (hue * 6, integer part)
    localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

    // Input request payload
    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
        logic [15:0] alpha_in;
    } t_request;

    // Result payload
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha_out;
    } t_result;

    // Scaled channel candidates handed from the core to the output stage
    typedef struct packed {
        logic        valid;
        logic        grey;
        logic [2:0]  sector;
        logic [15:0] v;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] t;
        logic [15:0] alpha;
    } t_mix;

endpackage

FILE: rtl/hsvrgb_core.sv
// Three-stage arithmetic core: sector split, saturation products, value scaling.
module hsvrgb_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  hsvrgb_pkg::t_request i_request,
    output hsvrgb_pkg::t_mix     o_mix
);

    // Stage 1 registers
    logic        r_s1_valid;
    logic [2:0]  r_s1_sector;
    logic [15:0] r_s1_f;
    logic [15:0] r_s1_s;
    logic [15:0] r_s1_v;
    logic [15:0] r_s1_a;

    // Stage 2 registers
    logic        r_s2_valid;
    logic [2:0]  r_s2_sector;
    logic        r_s2_grey;
    logic [15:0] r_s2_kp;
    logic [15:0] r_s2_kq;
    logic [15:0] r_s2_kt;
    logic [15:0] r_s2_v;
    logic [15:0] r_s2_a;

    // Stage 3 registers
    logic        r_s3_valid;
    logic [2:0]  r_s3_sector;
    logic        r_s3_grey;
    logic [15:0] r_s3_v;
    logic [15:0] r_s3_p;
    logic [15:0] r_s3_q;
    logic [15:0] r_s3_t;
    logic [15:0] r_s3_a;

    logic [18:0] n_x;
    logic [15:0] n_s;
    logic [15:0] n_v;
    logic [16:0] n_fc;
    logic [31:0] n_sf_full;
    logic [32:0] n_sg_full;
    logic [15:0] n_sf;
    logic [15:0] n_sg;
    logic [31:0] n_p_full;
    logic [31:0] n_q_full;
    logic [31:0] n_t_full;

    // Stage 1: clamp saturation and value, multiply hue by six with shift-add
    always_comb begin
        n_x = {1'b0, i_request.hue, 2'b00} + {2'b00, i_request.hue, 1'b0};
        n_s = (i_request.saturation > hsvrgb_pkg::ONE_Q15) ? hsvrgb_pkg::ONE_Q15
                                                            : i_request.saturation;
        n_v = (i_request.brightness > hsvrgb_pkg::ONE_Q15) ? hsvrgb_pkg::ONE_Q15
                                                            : i_request.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
        r_s1_sector <= n_x[18:16];
        r_s1_f      <= n_x[15:0];
        r_s1_s      <= n_s;
        r_s1_v      <= n_v;
        r_s1_a      <= i_request.alpha_in;
    end

    // Stage 2: s*f and s*(1-f), then form the three value coefficients
    always_comb begin
        n_fc      = 17'h10000 - {1'b0, r_s1_f};
        n_sf_full = {16'd0, r_s1_s} * {16'd0, r_s1_f};
        n_sg_full = {17'd0, r_s1_s} * {16'd0, n_fc};
        n_sf      = n_sf_full[31:16];
        n_sg      = n_sg_full[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_sector <= r_s1_sector;
        r_s2_grey   <= (r_s1_s == 16'd0);
        r_s2_kp     <= hsvrgb_pkg::ONE_Q15 - r_s1_s;
        r_s2_kq     <= hsvrgb_pkg::ONE_Q15 - n_sf;
        r_s2_kt     <= hsvrgb_pkg::ONE_Q15 - n_sg;
        r_s2_v      <= r_s1_v;
        r_s2_a      <= r_s1_a;
    end

    // Stage 3: scale value by each coefficient, truncate back to Q1.15
    always_comb begin
        n_p_full = {16'd0, r_s2_v} * {16'd0, r_s2_kp};
        n_q_full = {16'd0, r_s2_v} * {16'd0, r_s2_kq};
        n_t_full = {16'd0, r_s2_v} * {16'd0, r_s2_kt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_sector <= r_s2_sector;
        r_s3_grey   <= r_s2_grey;
        r_s3_v      <= r_s2_v;
        r_s3_p      <= n_p_full[30:15];
        r_s3_q      <= n_q_full[30:15];
        r_s3_t      <= n_t_full[30:15];
        r_s3_a      <= r_s2_a;
    end

    // Hand candidates to the output stage
    always_comb begin
        o_mix.valid  = r_s3_valid;
        o_mix.grey   = r_s3_grey;
        o_mix.sector = r_s3_sector;
        o_mix.v      = r_s3_v;
        o_mix.p      = r_s3_p;
        o_mix.q      = r_s3_q;
        o_mix.t      = r_s3_t;
        o_mix.alpha  = r_s3_a;
    end

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB converter.
//
//  port group          dir  timing
//  i_start/i_request   in   request taken when i_start is high and o_busy low
//  o_done/o_result     out  one-cycle strobe, result valid only in that cycle
//
// A request passes through the registered stages in this order: sector
// split, saturation products, value scaling, channel selection.
// One request can be taken every cycle; o_busy stays low since nothing stalls.
// Synchronous reset clears only the valid bits; data registers keep whatever.
module hsv_to_rgb_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  hsvrgb_pkg::t_request i_request,
    output logic                 o_busy,
    output logic                 o_done,
    output hsvrgb_pkg::t_result  o_result
);

    hsvrgb_pkg::t_mix    w_mix;
    hsvrgb_pkg::t_result n_result;
    hsvrgb_pkg::t_result r_result;
    logic                r_done;

    assign o_busy = 1'b0;

    hsvrgb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_start),
        .i_request (i_request),
        .o_mix     (w_mix)
    );

    // Route v, p, q, t to the channels by sector
    always_comb begin
        n_result.red       = w_mix.v;
        n_result.green     = w_mix.v;
        n_result.blue      = w_mix.v;
        n_result.alpha_out = w_mix.alpha;
        if (!w_mix.grey) begin
            unique case (w_mix.sector)
                hsvrgb_pkg::SECTOR_YELLOW_GREEN: begin
                    n_result.red  = w_mix.q;
                    n_result.blue = w_mix.p;
                end
                hsvrgb_pkg::SECTOR_GREEN_CYAN: begin
                    n_result.red  = w_mix.p;
                    n_result.blue = w_mix.t;
                end
                hsvrgb_pkg::SECTOR_CYAN_BLUE: begin
                    n_result.red   = w_mix.p;
                    n_result.green = w_mix.q;
                end
                hsvrgb_pkg::SECTOR_BLUE_MAGENTA: begin
                    n_result.red   = w_mix.t;
                    n_result.green = w_mix.p;
                end
                hsvrgb_pkg::SECTOR_MAGENTA_RED: begin
                    n_result.green = w_mix.p;
                    n_result.blue  = w_mix.q;
                end
                default: begin
                    n_result.green = w_mix.t;
                    n_result.blue  = w_mix.p;
                end
            endcase
        end
    end

    // Register the result and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_mix.valid;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted request comes out as an o_done strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_done)
        else $error("request did not complete after four cycles");

    // No result without a matching earlier request
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 4))
        else $error("result strobe without a matching request");

    // Alpha travels unchanged through the pipe
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.alpha_out == $past(i_request.alpha_in, 4)))
        else $error("alpha changed in flight");

    // Colour channels never exceed one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.red <= hsvrgb_pkg::ONE_Q15)
                && (o_result.green <= hsvrgb_pkg::ONE_Q15)
                && (o_result.blue <= hsvrgb_pkg::ONE_Q15))
        else $error("colour channel above one");

endmodule
